// ===== rtl/dtq_pkg.sv =====
// Shared types, widths and status codes for the delta-list timer queue.
package dtq_pkg;

  localparam int ID_W     = 6;
  localparam int DELTA_W  = 32;
  localparam int STATUS_W = 3;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int ID_COUNT_DEF    = 64;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_DELETE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_ZERO     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd3;
  localparam logic [STATUS_W-1:0] ST_DUP      = 3'd4;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [DELTA_W-1:0] delta;
  } entry_t;

endpackage

// ===== rtl/delta_timer_queue_unit.sv =====
// Top level: delta-list timer queue, sequencer walking the slot memory.
//
//  channel  | ports                                        | handshake
//  ---------+----------------------------------------------+-------------------------
//  input    | in_kind, in_entry_id, in_timeout             | start & !busy
//  result   | out_status, out_count, out_head_id/_delta    | out_valid, one cycle
//
// An insert or a delete walks the slot memory once to search, then again to shift
// entries, one entry per cycle through the single read port. A zero timeout, a bad
// id or an empty queue gets its result on the cycle after the accept; a duplicate,
// a full queue, a missing id or a tail insert or delete gets it after the search
// alone. Reset is synchronous and empties the queue; slot contents need no clearing.
// Results cannot be held off by the receiver.
module delta_timer_queue_unit #(
  parameter int QUEUE_DEPTH = dtq_pkg::QUEUE_DEPTH_DEF,
  parameter int ID_COUNT    = dtq_pkg::ID_COUNT_DEF,
  parameter int AW          = $clog2(QUEUE_DEPTH),
  parameter int CW          = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_kind,
  input  logic [dtq_pkg::ID_W-1:0]      in_entry_id,
  input  logic [dtq_pkg::DELTA_W-1:0]   in_timeout,
  output logic                          out_valid,
  output logic [dtq_pkg::STATUS_W-1:0]  out_status,
  output logic [CW-1:0]                 out_count,
  output logic [dtq_pkg::ID_W-1:0]      out_head_id,
  output logic [dtq_pkg::DELTA_W-1:0]   out_head_delta
);

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_SCAN      = 3'd1;
  localparam logic [2:0] S_DECIDE    = 3'd2;
  localparam logic [2:0] S_SHIFT_INS = 3'd3;
  localparam logic [2:0] S_PLACE     = 3'd4;
  localparam logic [2:0] S_SHIFT_DEL = 3'd5;

  localparam logic [CW-1:0] DEPTH_FULL = CW'(QUEUE_DEPTH);
  localparam logic [31:0]   ID_LIMIT   = 32'(ID_COUNT);

  logic [2:0]                         state_r;
  logic                               kind_r;
  logic [dtq_pkg::ID_W-1:0]           id_r;
  logic [dtq_pkg::DELTA_W-1:0]        rem_r;
  logic                               placed_r;
  logic [AW-1:0]                      pos_r;
  logic [dtq_pkg::DELTA_W-1:0]        cut_r;
  logic                               found_r;
  logic [AW-1:0]                      fpos_r;
  logic [dtq_pkg::DELTA_W-1:0]        del_delta_r;
  logic [CW-1:0]                      occ_r;
  dtq_pkg::entry_t                    head_r;
  logic [CW-1:0]                      ra_r;
  logic                               iss_r;
  logic                               rv_r;
  logic [AW-1:0]                      rdi_r;
  logic                               out_valid_r;
  logic [dtq_pkg::STATUS_W-1:0]       status_r;

  logic                               accept;
  logic                               id_bad;
  logic [CW-1:0]                      occ_m1;
  logic                               last_rd;
  logic                               mem_re;
  logic [AW-1:0]                      mem_raddr;
  logic                               mem_we;
  logic [AW-1:0]                      mem_waddr;
  dtq_pkg::entry_t                    mem_wdata;
  dtq_pkg::entry_t                    rd_data;

  assign busy    = (state_r != S_IDLE);
  assign accept  = start && !busy;
  assign id_bad  = (32'(in_entry_id) >= ID_LIMIT);
  assign occ_m1  = occ_r - CW'(1);
  assign last_rd = rv_r && (CW'(rdi_r) == occ_m1);

  dtq_mem #(
    .DEPTH (QUEUE_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (rd_data)
  );

  // Memory requests per state
  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = ra_r[AW-1:0];
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = rd_data;
    unique case (state_r)
      S_IDLE: begin
        if (accept && in_kind == dtq_pkg::KIND_INSERT && in_timeout != '0 && !id_bad &&
            occ_r == '0) begin
          mem_we          = 1'b1;
          mem_wdata.id    = in_entry_id;
          mem_wdata.delta = in_timeout;
        end
      end
      S_SCAN: begin
        mem_re = (ra_r < occ_r);
      end
      S_DECIDE: begin
        if (kind_r == dtq_pkg::KIND_INSERT && !found_r && occ_r != DEPTH_FULL && !placed_r) begin
          mem_we          = 1'b1;
          mem_waddr       = occ_r[AW-1:0];
          mem_wdata.id    = id_r;
          mem_wdata.delta = rem_r;
        end
      end
      S_SHIFT_INS: begin
        mem_re = iss_r;
        if (rv_r) begin
          // move down one slot; the entry displaced by the new one keeps only its cut
          mem_we    = 1'b1;
          mem_waddr = rdi_r + AW'(1);
          if (rdi_r == pos_r) begin
            mem_wdata.delta = cut_r;
          end
        end
      end
      S_PLACE: begin
        mem_we          = 1'b1;
        mem_waddr       = pos_r;
        mem_wdata.id    = id_r;
        mem_wdata.delta = rem_r;
      end
      S_SHIFT_DEL: begin
        mem_re = iss_r;
        if (rv_r) begin
          // close the gap; the successor absorbs the removed delta
          mem_we    = 1'b1;
          mem_waddr = rdi_r - AW'(1);
          if (rdi_r == fpos_r + AW'(1)) begin
            mem_wdata.delta = rd_data.delta + del_delta_r;
          end
        end
      end
      default: begin
        mem_re = 1'b0;
      end
    endcase
  end

  // Track slot 0 so the head is always at hand
  always_ff @(posedge clk) begin
    if (mem_we && mem_waddr == '0) begin
      head_r <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdi_r <= mem_raddr;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
      rv_r        <= 1'b0;
      iss_r       <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      rv_r        <= mem_re;
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            kind_r   <= in_kind;
            id_r     <= in_entry_id;
            rem_r    <= in_timeout;
            placed_r <= 1'b0;
            found_r  <= 1'b0;
            ra_r     <= '0;
            if (in_kind == dtq_pkg::KIND_INSERT && in_timeout == '0) begin
              status_r    <= dtq_pkg::ST_ZERO;
              out_valid_r <= 1'b1;
            end else if (id_bad) begin
              status_r    <= dtq_pkg::ST_NOTFOUND;
              out_valid_r <= 1'b1;
            end else if (occ_r == '0) begin
              out_valid_r <= 1'b1;
              if (in_kind == dtq_pkg::KIND_INSERT) begin
                occ_r    <= CW'(1);
                status_r <= dtq_pkg::ST_OK;
              end else begin
                status_r <= dtq_pkg::ST_NOTFOUND;
              end
            end else begin
              state_r <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (mem_re) begin
            ra_r <= ra_r + CW'(1);
          end
          if (rv_r) begin
            if (rd_data.id == id_r) begin
              found_r     <= 1'b1;
              fpos_r      <= rdi_r;
              del_delta_r <= rd_data.delta;
            end
            if (!placed_r) begin
              if (rd_data.delta <= rem_r) begin
                rem_r <= rem_r - rd_data.delta;
              end else begin
                placed_r <= 1'b1;
                pos_r    <= rdi_r;
                cut_r    <= rd_data.delta - rem_r;
              end
            end
            if (last_rd) begin
              state_r <= S_DECIDE;
            end
          end
        end
        S_DECIDE: begin
          if (kind_r == dtq_pkg::KIND_INSERT) begin
            if (found_r) begin
              status_r    <= dtq_pkg::ST_DUP;
              out_valid_r <= 1'b1;
              state_r     <= S_IDLE;
            end else if (occ_r == DEPTH_FULL) begin
              status_r    <= dtq_pkg::ST_FULL;
              out_valid_r <= 1'b1;
              state_r     <= S_IDLE;
            end else if (!placed_r) begin
              occ_r       <= occ_r + CW'(1);
              status_r    <= dtq_pkg::ST_OK;
              out_valid_r <= 1'b1;
              state_r     <= S_IDLE;
            end else begin
              ra_r    <= occ_m1;
              iss_r   <= 1'b1;
              state_r <= S_SHIFT_INS;
            end
          end else begin
            if (!found_r) begin
              status_r    <= dtq_pkg::ST_NOTFOUND;
              out_valid_r <= 1'b1;
              state_r     <= S_IDLE;
            end else if (CW'(fpos_r) == occ_m1) begin
              // tail entry: drop it, nothing else moves
              occ_r       <= occ_m1;
              status_r    <= dtq_pkg::ST_OK;
              out_valid_r <= 1'b1;
              state_r     <= S_IDLE;
            end else begin
              ra_r    <= CW'(fpos_r) + CW'(1);
              iss_r   <= 1'b1;
              state_r <= S_SHIFT_DEL;
            end
          end
        end
        S_SHIFT_INS: begin
          if (iss_r) begin
            if (ra_r[AW-1:0] == pos_r) begin
              iss_r <= 1'b0;
            end else begin
              ra_r <= ra_r - CW'(1);
            end
          end
          if (rv_r && rdi_r == pos_r) begin
            state_r <= S_PLACE;
          end
        end
        S_PLACE: begin
          occ_r       <= occ_r + CW'(1);
          status_r    <= dtq_pkg::ST_OK;
          out_valid_r <= 1'b1;
          state_r     <= S_IDLE;
        end
        S_SHIFT_DEL: begin
          if (iss_r) begin
            if (ra_r == occ_m1) begin
              iss_r <= 1'b0;
            end else begin
              ra_r <= ra_r + CW'(1);
            end
          end
          if (last_rd) begin
            occ_r       <= occ_m1;
            status_r    <= dtq_pkg::ST_OK;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = status_r;
  assign out_count      = occ_r;
  assign out_head_id    = (occ_r != '0) ? head_r.id : '0;
  assign out_head_delta = (occ_r != '0) ? head_r.delta : '0;

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= DEPTH_FULL)
    else $error("occupancy above queue depth");

  a_beat_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> state_r == S_IDLE)
    else $error("result beat while the sequencer is still busy");

  a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_re && mem_we) |-> mem_raddr != mem_waddr)
    else $error("read and write to the same slot in one cycle");

  a_occ_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && !start) |=> occ_r == $past(occ_r))
    else $error("occupancy changed with no item in flight");

  a_place_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_PLACE |-> (placed_r && occ_r != DEPTH_FULL))
    else $error("placing an entry without a found position or room");

endmodule

// ===== rtl/dtq_mem.sv =====
// Slot memory: one write port, one read port, registered read data.
module dtq_mem #(
  parameter int DEPTH = dtq_pkg::QUEUE_DEPTH_DEF,
  parameter int AW    = $clog2(dtq_pkg::QUEUE_DEPTH_DEF)
) (
  input  logic           clk,
  input  logic           we,
  input  logic [AW-1:0]  waddr,
  input  dtq_pkg::entry_t wdata,
  input  logic           re,
  input  logic [AW-1:0]  raddr,
  output dtq_pkg::entry_t rdata
);

  dtq_pkg::entry_t mem [DEPTH];
  dtq_pkg::entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rd_data_r <= mem[raddr];
    end
  end

  assign rdata = rd_data_r;

endmodule
